FILE: src/fua_pkg.sv
`timescale 1ns / 1ps
// Shared constants, types and helpers for the H.264 RTP FU-A packetizer.
// No dependencies.
package fua_pkg;

   localparam int unsigned PAYLOAD_MAX = 1400;
   localparam logic [4:0]  FUA_TYPE    = 5'd28;
   localparam logic [15:0] SEQ_TOP     = 16'hFFFF;

   // reciprocal for ceil(len / PAYLOAD_MAX), exact for 17-bit dividends
   localparam logic [32:0] RECIP =
      33'(((64'd1 << 32) + 64'(PAYLOAD_MAX) - 64'd1) / 64'(PAYLOAD_MAX));

   localparam logic [31:0] SSRC_RESET = 32'd1000;
   localparam logic [6:0]  PT_RESET   = 7'd96;

   localparam logic [0:0] CSR_SSRC = 1'b0;
   localparam logic [0:0] CSR_PT   = 1'b1;

   typedef struct packed {
      logic [7:0] data_byte;
      logic       packet_start;
      logic       packet_end;
      logic       marker;
   } entry_type;

   typedef struct packed {
      entry_type [2:0] ent;
      logic [1:0]      count;
      logic [15:0]     seq_num;
      logic [31:0]     stamp;
   } list_type;

   typedef struct packed {
      logic [31:0] ssrc;
      logic [6:0]  pt;
   } cfg_type;

   function automatic logic [15:0] next_seq(input logic [15:0] seq, input logic [15:0] count);
      logic [15:0] room;
      room = SEQ_TOP - seq;
      if (room < count) begin
         next_seq = 16'd0;
      end else begin
         next_seq = seq + 16'd1;
      end
   endfunction

endpackage

FILE: src/fua_if.sv
`timescale 1ns / 1ps
// Valid/ready channel interfaces for NAL byte input and RTP payload output.
// Depends on nothing.
interface fua_req_if;
   logic        valid;
   logic        ready;
   logic [7:0]  nal_byte;
   logic        nal_first;
   logic        nal_last;
   logic [15:0] nal_length;
   logic [31:0] frame_time;

   modport source(output valid, nal_byte, nal_first, nal_last, nal_length, frame_time,
                  input ready);
   modport sink(input valid, nal_byte, nal_first, nal_last, nal_length, frame_time,
                output ready);
endinterface

interface fua_rsp_if;
   logic        valid;
   logic        ready;
   logic [7:0]  data_byte;
   logic        packet_start;
   logic        packet_end;
   logic [15:0] seq_num;
   logic [31:0] stamp;
   logic        marker;
   logic [6:0]  pt_out;
   logic [31:0] ssrc_out;
   logic        item_end;

   modport source(output valid, data_byte, packet_start, packet_end, seq_num, stamp,
                  marker, pt_out, ssrc_out, item_end, input ready);
   modport sink(input valid, data_byte, packet_start, packet_end, seq_num, stamp,
                marker, pt_out, ssrc_out, item_end, output ready);
endinterface

FILE: src/h264_rtp_fua_packetizer.sv
`timescale 1ns / 1ps
// H.264 RTP packetizer with FU-A fragmentation; top level.
// The first result beat is valid in the cycle after its input beat is accepted.
// Throughput (result list register): one beat per cycle while the output is ready;
// a byte opening an FU-A fragment yields two or three beats; input waits for them.
// Reset is synchronous: clears state, SSRC to 1000, payload type to 96.
module h264_rtp_fua_packetizer import fua_pkg::*; (
   input  logic        clock,
   input  logic        reset,
   fua_req_if.sink     req_bus,
   fua_rsp_if.source   rsp_bus,
   input  logic        csr_we,
   input  logic [0:0]  csr_index,
   input  logic [31:0] csr_wdata
);

   cfg_type  cfg;
   list_type list;
   logic     free;
   logic     accept;

   assign req_bus.ready = free;
   assign accept        = req_bus.valid && free;

   fua_csr u_csr (
      .clock     (clock),
      .reset     (reset),
      .csr_we    (csr_we),
      .csr_index (csr_index),
      .csr_wdata (csr_wdata),
      .cfg       (cfg)
   );

   fua_core u_core (
      .clock      (clock),
      .reset      (reset),
      .accept     (accept),
      .nal_byte   (req_bus.nal_byte),
      .nal_first  (req_bus.nal_first),
      .nal_last   (req_bus.nal_last),
      .nal_length (req_bus.nal_length),
      .frame_time (req_bus.frame_time),
      .list       (list)
   );

   fua_emit u_emit (
      .clock (clock),
      .reset (reset),
      .load  (accept),
      .list  (list),
      .cfg   (cfg),
      .free  (free),
      .rsp   (rsp_bus)
   );

   a_fu_start : assert property (@(posedge clock) disable iff (reset)
      rsp_bus.valid && rsp_bus.packet_start && !rsp_bus.item_end
      |-> rsp_bus.data_byte[4:0] == FUA_TYPE)
      else $error("fragment start beat is not an FU indicator");

   a_no_overrun : assert property (@(posedge clock) disable iff (reset)
      req_bus.valid && req_bus.ready && rsp_bus.valid
      |-> rsp_bus.ready && rsp_bus.item_end)
      else $error("input beat taken while result beats pending");

   a_reset_idle : assert property (@(posedge clock)
      !reset && $past(reset) |-> !rsp_bus.valid)
      else $error("result valid right after reset");

   a_seq_hold : assert property (@(posedge clock) disable iff (reset)
      rsp_bus.valid && rsp_bus.ready && !rsp_bus.item_end
      |=> $stable(rsp_bus.seq_num))
      else $error("sequence number changed within one item");

endmodule

FILE: src/fua_csr.sv
`timescale 1ns / 1ps
// Configuration registers: SSRC and payload type.
// Depends on fua_pkg.
module fua_csr import fua_pkg::*; (
   input  logic        clock,
   input  logic        reset,
   input  logic        csr_we,
   input  logic [0:0]  csr_index,
   input  logic [31:0] csr_wdata,
   output cfg_type     cfg
);

   cfg_type cfg_ff, cfg_in;

   always_comb begin
      cfg_in = cfg_ff;
      if (csr_we) begin
         case (csr_index)
            CSR_SSRC: cfg_in.ssrc = csr_wdata;
            CSR_PT:   cfg_in.pt   = csr_wdata[6:0];
            default:  cfg_in      = cfg_ff;
         endcase
      end
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         cfg_ff.ssrc <= SSRC_RESET;
         cfg_ff.pt   <= PT_RESET;
      end else begin
         cfg_ff <= cfg_in;
      end
   end

   assign cfg = cfg_ff;

endmodule

FILE: src/fua_core.sv
`timescale 1ns / 1ps
// Packetizer state and per-byte result list: single packet or FU-A fragments.
// Depends on fua_pkg.
module fua_core import fua_pkg::*; (
   input  logic        clock,
   input  logic        reset,
   input  logic        accept,
   input  logic [7:0]  nal_byte,
   input  logic        nal_first,
   input  logic        nal_last,
   input  logic [15:0] nal_length,
   input  logic [31:0] frame_time,
   output list_type    list
);

   logic [15:0] seq_ff, seq_in;
   logic        frag_ff, frag_in;
   logic [7:0]  saved_ff, saved_in;
   logic [15:0] pkts_ff, pkts_in;
   logic [15:0] left_ff, left_in;
   logic [11:0] bip_ff, bip_in;
   logic        ffrag_ff, ffrag_in;
   logic [31:0] stamp_ff, stamp_in;

   logic [16:0] dividend;
   logic [49:0] product;
   logic [15:0] pkt_count;
   logic [15:0] len_dec;
   logic        lastpkt;
   logic        lp;
   logic        newpkt;
   logic [11:0] bip_eff;
   logic [12:0] bip_next;
   logic [16:0] span;
   logic        endpkt;
   logic [7:0]  fu_ind;
   logic [7:0]  fu_hdr;
   logic [1:0]  dpos;

   assign dividend  = {1'b0, nal_length} + 17'(PAYLOAD_MAX - 1);
   assign product   = 50'(dividend) * 50'(RECIP);
   assign pkt_count = product[47:32];
   assign len_dec   = nal_length - 16'd1;

   always_comb begin
      seq_in   = seq_ff;
      frag_in  = frag_ff;
      saved_in = saved_ff;
      pkts_in  = pkts_ff;
      left_in  = left_ff;
      bip_in   = bip_ff;
      ffrag_in = ffrag_ff;
      stamp_in = stamp_ff;
      list     = '0;
      lastpkt  = 1'b0;
      lp       = 1'b0;
      newpkt   = 1'b0;
      bip_eff  = bip_ff;
      bip_next = '0;
      span     = '0;
      endpkt   = 1'b0;
      fu_ind   = '0;
      fu_hdr   = '0;
      dpos     = 2'd0;

      if (nal_first) begin
         stamp_in = frame_time;
         if (pkt_count <= 16'd1) begin
            frag_in  = 1'b0;
            pkts_in  = 16'd1;
            left_in  = (nal_last || nal_length <= 16'd1) ? 16'd0 : len_dec;
            bip_in   = 12'd1;
            seq_in   = next_seq(seq_ff, 16'd1);
            list.ent[0] = '{data_byte: nal_byte, packet_start: 1'b1,
                            packet_end: (left_in == 16'd0), marker: 1'b1};
            list.count  = 2'd1;
         end else begin
            frag_in  = 1'b1;
            saved_in = nal_byte;
            pkts_in  = pkt_count;
            bip_in   = 12'd0;
            seq_in   = next_seq(seq_ff, pkt_count);
            lastpkt  = ({1'b0, len_dec} <= 17'(PAYLOAD_MAX)) || nal_last;
            fu_ind   = {nal_byte[7:5], FUA_TYPE};
            fu_hdr   = {1'b1, lastpkt, 1'b0, nal_byte[4:0]};
            list.ent[0] = '{data_byte: fu_ind, packet_start: 1'b1,
                            packet_end: 1'b0, marker: lastpkt};
            list.ent[1] = '{data_byte: fu_hdr, packet_start: 1'b0,
                            packet_end: nal_last, marker: lastpkt};
            list.count  = 2'd2;
            ffrag_in = 1'b0;
            left_in  = nal_last ? 16'd0 : len_dec;
         end
      end else if (left_ff != 16'd0) begin
         if (!frag_ff) begin
            left_in = nal_last ? 16'd0 : left_ff - 16'd1;
            list.ent[0] = '{data_byte: nal_byte, packet_start: 1'b0,
                            packet_end: (left_in == 16'd0), marker: 1'b1};
            list.count  = 2'd1;
         end else begin
            newpkt = {1'b0, bip_ff} >= 13'(PAYLOAD_MAX);
            if (newpkt) begin
               lp       = {1'b0, left_ff} <= 17'(PAYLOAD_MAX);
               bip_eff  = 12'd0;
               seq_in   = next_seq(seq_ff, pkts_ff);
               fu_ind   = {saved_ff[7:5], FUA_TYPE};
               fu_hdr   = {ffrag_ff, lp, 1'b0, saved_ff[4:0]};
               list.ent[0] = '{data_byte: fu_ind, packet_start: 1'b1,
                               packet_end: 1'b0, marker: lp};
               list.ent[1] = '{data_byte: fu_hdr, packet_start: 1'b0,
                               packet_end: 1'b0, marker: lp};
               ffrag_in = 1'b0;
               dpos     = 2'd2;
            end
            span     = {1'b0, left_ff} + 17'(bip_eff);
            lastpkt  = span <= 17'(PAYLOAD_MAX);
            left_in  = nal_last ? 16'd0 : left_ff - 16'd1;
            bip_next = 13'(bip_eff) + 13'd1;
            bip_in   = bip_next[11:0];
            endpkt   = (left_in == 16'd0) || (bip_next >= 13'(PAYLOAD_MAX));
            list.ent[dpos] = '{data_byte: nal_byte, packet_start: 1'b0,
                               packet_end: endpkt,
                               marker: lastpkt || (left_in == 16'd0)};
            list.count = newpkt ? 2'd3 : 2'd1;
         end
      end

      list.seq_num = seq_in;
      list.stamp   = stamp_in;
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         seq_ff   <= '0;
         frag_ff  <= 1'b0;
         saved_ff <= '0;
         pkts_ff  <= '0;
         left_ff  <= '0;
         bip_ff   <= '0;
         ffrag_ff <= 1'b1;
         stamp_ff <= '0;
      end else if (accept) begin
         seq_ff   <= seq_in;
         frag_ff  <= frag_in;
         saved_ff <= saved_in;
         pkts_ff  <= pkts_in;
         left_ff  <= left_in;
         bip_ff   <= bip_in;
         ffrag_ff <= ffrag_in;
         stamp_ff <= stamp_in;
      end
   end

endmodule

FILE: src/fua_emit.sv
`timescale 1ns / 1ps
// Result list register: up to three beats, one sent per ready cycle.
// Depends on fua_pkg and fua_rsp_if.
module fua_emit import fua_pkg::*; (
   input  logic       clock,
   input  logic       reset,
   input  logic       load,
   input  list_type   list,
   input  cfg_type    cfg,
   output logic       free,
   fua_rsp_if.source  rsp
);

   list_type   list_ff;
   logic [1:0] cnt_ff, cnt_in;
   logic [1:0] idx_ff, idx_in;
   entry_type  cur;
   logic       at_end;
   logic       take;

   assign cur    = list_ff.ent[idx_ff];
   assign at_end = idx_ff == (cnt_ff - 2'd1);
   assign take   = rsp.valid && rsp.ready;
   assign free   = (cnt_ff == 2'd0) || (take && at_end);

   always_comb begin
      cnt_in = cnt_ff;
      idx_in = idx_ff;
      if (load) begin
         cnt_in = list.count;
         idx_in = 2'd0;
      end else if (take && at_end) begin
         cnt_in = 2'd0;
         idx_in = 2'd0;
      end else if (take) begin
         idx_in = idx_ff + 2'd1;
      end
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         cnt_ff <= '0;
         idx_ff <= '0;
      end else begin
         cnt_ff <= cnt_in;
         idx_ff <= idx_in;
      end
   end

   always_ff @(posedge clock) begin
      if (load) begin
         list_ff <= list;
      end
   end

   assign rsp.valid        = cnt_ff != 2'd0;
   assign rsp.data_byte    = cur.data_byte;
   assign rsp.packet_start = cur.packet_start;
   assign rsp.packet_end   = cur.packet_end;
   assign rsp.marker       = cur.marker;
   assign rsp.seq_num      = list_ff.seq_num;
   assign rsp.stamp        = list_ff.stamp;
   assign rsp.pt_out       = cfg.pt;
   assign rsp.ssrc_out     = cfg.ssrc;
   assign rsp.item_end     = at_end;

endmodule

FILE: tb/testbench.sv
`timescale 1ns / 1ps
// Self-checking testbench for h264_rtp_fua_packetizer: NAL byte beats in, RTP payload beats
// out, each compared field by field against an in-bench packetizer model.
// Depends on fua_pkg and the fua_req_if / fua_rsp_if interfaces.
module testbench;
   import fua_pkg::*;

   localparam int CYCLE_LIMIT  = 2000000;
   localparam int SETTLE_TAIL  = 16;
   localparam int HOLDOFF_SPAN = 300;

   typedef struct packed {
      logic [7:0]  nal_byte;
      logic        nal_first;
      logic        nal_last;
      logic [15:0] nal_length;
      logic [31:0] frame_time;
   } nal_beat_t;

   typedef struct packed {
      logic [7:0]  data_byte;
      logic        packet_start;
      logic        packet_end;
      logic [15:0] seq_num;
      logic [31:0] stamp;
      logic        marker;
      logic [6:0]  pt_out;
      logic [31:0] ssrc_out;
      logic        item_end;
   } rtp_beat_t;

   logic        clock = 1'b0;
   logic        reset = 1'b1;
   logic        csr_we;
   logic [0:0]  csr_index;
   logic [31:0] csr_wdata;

   fua_req_if req_bus();
   fua_rsp_if rsp_bus();

   h264_rtp_fua_packetizer dut (
      .clock     (clock),
      .reset     (reset),
      .req_bus   (req_bus),
      .rsp_bus   (rsp_bus),
      .csr_we    (csr_we),
      .csr_index (csr_index),
      .csr_wdata (csr_wdata)
   );

   nal_beat_t pending_nal_bytes[$];
   rtp_beat_t expected_payload[$];

   int cycle_count        = 0;
   int mismatch_count     = 0;
   int nal_beats_taken    = 0;
   int payload_beats_seen = 0;
   bit req_taken          = 1'b0;
   bit rsp_hold           = 1'b0;
   bit steady             = 1'b0;

   // packetizer model state
   logic [31:0] cfg_ssrc      = SSRC_RESET;
   logic [6:0]  cfg_pt        = PT_RESET;
   logic [15:0] rtp_seq       = 16'd0;
   logic        fu_active     = 1'b0;
   logic [7:0]  fu_nal_header = 8'd0;
   logic [15:0] fu_count      = 16'd0;
   logic [15:0] nal_remaining = 16'd0;
   logic [11:0] frag_fill     = 12'd0;
   logic        fu_first      = 1'b1;
   logic [31:0] rtp_stamp     = 32'd0;

   always begin
      #5 clock = 1'b1;
      #5 clock = 1'b0;
   end

   always @(posedge clock) begin
      cycle_count <= cycle_count + 1;
   end

   function automatic rtp_beat_t make_beat(input logic [7:0] d, input logic ps, input logic pe,
                                           input logic mk);
      rtp_beat_t r;
      r.data_byte    = d;
      r.packet_start = ps;
      r.packet_end   = pe;
      r.seq_num      = rtp_seq;
      r.stamp        = rtp_stamp;
      r.marker       = mk;
      r.pt_out       = cfg_pt;
      r.ssrc_out     = cfg_ssrc;
      r.item_end     = 1'b0;
      return r;
   endfunction

   function automatic void bump_seq(input int count);
      if (int'(SEQ_TOP) - int'(rtp_seq) < count) begin
         rtp_seq = 16'd0;
      end else begin
         rtp_seq = rtp_seq + 16'd1;
      end
   endfunction

   function automatic void packetize(input nal_beat_t b);
      rtp_beat_t beats [3];
      int        n;
      int        cnt;
      int        len;
      logic      lastpkt;
      logic      lp;
      logic      endpkt;
      n = 0;
      len = int'(b.nal_length);
      if (b.nal_first) begin
         cnt = (len + int'(PAYLOAD_MAX) - 1) / int'(PAYLOAD_MAX);
         rtp_stamp = b.frame_time;
         if (cnt <= 1) begin
            fu_active = 1'b0;
            fu_count = 16'd1;
            nal_remaining = (len > 1) ? 16'(len - 1) : 16'd0;
            if (b.nal_last) begin
               nal_remaining = 16'd0;
            end
            frag_fill = 12'd1;
            bump_seq(1);
            beats[n] = make_beat(b.nal_byte, 1'b1, nal_remaining == 0, 1'b1);
            n++;
         end else begin
            fu_active = 1'b1;
            fu_nal_header = b.nal_byte;
            fu_count = 16'(cnt);
            nal_remaining = 16'(len - 1);
            frag_fill = 12'd0;
            fu_first = 1'b1;
            bump_seq(cnt);
            lastpkt = int'(nal_remaining) <= int'(PAYLOAD_MAX) || b.nal_last;
            beats[n] = make_beat({b.nal_byte[7:5], FUA_TYPE}, 1'b1, 1'b0, lastpkt);
            n++;
            beats[n] = make_beat({1'b1, lastpkt, 1'b0, b.nal_byte[4:0]}, 1'b0, b.nal_last,
                                 lastpkt);
            n++;
            fu_first = 1'b0;
            if (b.nal_last) begin
               nal_remaining = 16'd0;
            end
         end
      end else if (nal_remaining != 0) begin
         if (!fu_active) begin
            nal_remaining = nal_remaining - 16'd1;
            if (b.nal_last) begin
               nal_remaining = 16'd0;
            end
            beats[n] = make_beat(b.nal_byte, 1'b0, nal_remaining == 0, 1'b1);
            n++;
         end else begin
            if (int'(frag_fill) >= int'(PAYLOAD_MAX)) begin
               lp = int'(nal_remaining) <= int'(PAYLOAD_MAX);
               frag_fill = 12'd0;
               bump_seq(int'(fu_count));
               beats[n] = make_beat({fu_nal_header[7:5], FUA_TYPE}, 1'b1, 1'b0, lp);
               n++;
               beats[n] = make_beat({fu_first, lp, 1'b0, fu_nal_header[4:0]}, 1'b0, 1'b0, lp);
               n++;
               fu_first = 1'b0;
            end
            lastpkt = int'(nal_remaining) + int'(frag_fill) <= int'(PAYLOAD_MAX);
            nal_remaining = nal_remaining - 16'd1;
            frag_fill = frag_fill + 12'd1;
            if (b.nal_last) begin
               nal_remaining = 16'd0;
            end
            endpkt = nal_remaining == 0 || int'(frag_fill) >= int'(PAYLOAD_MAX);
            beats[n] = make_beat(b.nal_byte, 1'b0, endpkt, lastpkt || nal_remaining == 0);
            n++;
         end
      end
      if (n > 0) begin
         beats[n - 1].item_end = 1'b1;
      end
      for (int i = 0; i < n; i++) begin
         expected_payload.push_back(beats[i]);
      end
   endfunction

   task automatic report(input string what, input logic [31:0] got, input logic [31:0] want);
      $display("payload beat %0d: %s is %0h, expected %0h", payload_beats_seen, what, got, want);
      mismatch_count++;
   endtask

   task automatic check_beat(input rtp_beat_t got, input rtp_beat_t want);
      if (got.data_byte !== want.data_byte) report("data_byte", 32'(got.data_byte),
                                                   32'(want.data_byte));
      if (got.packet_start !== want.packet_start) report("packet_start", 32'(got.packet_start),
                                                         32'(want.packet_start));
      if (got.packet_end !== want.packet_end) report("packet_end", 32'(got.packet_end),
                                                     32'(want.packet_end));
      if (got.seq_num !== want.seq_num) report("seq_num", 32'(got.seq_num), 32'(want.seq_num));
      if (got.stamp !== want.stamp) report("stamp", got.stamp, want.stamp);
      if (got.marker !== want.marker) report("marker", 32'(got.marker), 32'(want.marker));
      if (got.pt_out !== want.pt_out) report("pt_out", 32'(got.pt_out), 32'(want.pt_out));
      if (got.ssrc_out !== want.ssrc_out) report("ssrc_out", got.ssrc_out, want.ssrc_out);
      if (got.item_end !== want.item_end) report("item_end", 32'(got.item_end),
                                                 32'(want.item_end));
   endtask

   always @(posedge clock) begin : payload_monitor
      rtp_beat_t got;
      rtp_beat_t want;
      nal_beat_t taken;
      if (!reset) begin
         if (rsp_bus.valid && rsp_bus.ready) begin
            got.data_byte    = rsp_bus.data_byte;
            got.packet_start = rsp_bus.packet_start;
            got.packet_end   = rsp_bus.packet_end;
            got.seq_num      = rsp_bus.seq_num;
            got.stamp        = rsp_bus.stamp;
            got.marker       = rsp_bus.marker;
            got.pt_out       = rsp_bus.pt_out;
            got.ssrc_out     = rsp_bus.ssrc_out;
            got.item_end     = rsp_bus.item_end;
            payload_beats_seen++;
            if (expected_payload.size() == 0) begin
               report("beat with nothing pending, data_byte", 32'(got.data_byte), 32'd0);
            end else begin
               want = expected_payload.pop_front();
               check_beat(got, want);
            end
         end
         req_taken = req_bus.valid && req_bus.ready;
         if (req_taken) begin
            taken.nal_byte   = req_bus.nal_byte;
            taken.nal_first  = req_bus.nal_first;
            taken.nal_last   = req_bus.nal_last;
            taken.nal_length = req_bus.nal_length;
            taken.frame_time = req_bus.frame_time;
            packetize(taken);
            nal_beats_taken++;
         end
      end
   end

   always @(negedge clock) begin : nal_driver
      nal_beat_t next_beat;
      if (reset) begin
         req_bus.valid <= 1'b0;
      end else if (!req_bus.valid || req_taken) begin
         if (pending_nal_bytes.size() != 0 && (steady || $urandom_range(99) >= 25)) begin
            next_beat = pending_nal_bytes.pop_front();
            req_bus.valid      <= 1'b1;
            req_bus.nal_byte   <= next_beat.nal_byte;
            req_bus.nal_first  <= next_beat.nal_first;
            req_bus.nal_last   <= next_beat.nal_last;
            req_bus.nal_length <= next_beat.nal_length;
            req_bus.frame_time <= next_beat.frame_time;
         end else begin
            req_bus.valid <= 1'b0;
         end
      end
   end

   always @(negedge clock) begin : payload_ready
      rsp_bus.ready <= !reset && !rsp_hold && (steady || $urandom_range(99) >= 25);
   end

   // hold the output back long enough to back the block up into its input
   initial begin : rsp_holdoff
      wait (nal_beats_taken >= 60);
      rsp_hold = 1'b1;
      repeat (HOLDOFF_SPAN) @(posedge clock);
      rsp_hold = 1'b0;
   end

   initial begin : watchdog
      wait (cycle_count >= CYCLE_LIMIT);
      $display("simulation failed");
      $finish;
   end

   task automatic add_item(input int unsigned b, input int unsigned first,
                           input int unsigned last, input int unsigned len,
                           input int unsigned stamp);
      nal_beat_t item;
      item.nal_byte   = 8'(b);
      item.nal_first  = 1'(first);
      item.nal_last   = 1'(last);
      item.nal_length = 16'(len);
      item.frame_time = stamp;
      pending_nal_bytes.push_back(item);
   endtask

   task automatic add_nal(input int unsigned len_field, input int unsigned count,
                          input int unsigned flag_last);
      int unsigned stamp;
      stamp = $urandom;
      for (int unsigned i = 0; i < count; i++) begin
         add_item($urandom_range(255), i == 0, (i == count - 1) && flag_last != 0,
                  (i == 0) ? len_field : $urandom_range(65535),
                  (i == 0) ? stamp : $urandom);
      end
   endtask

   task automatic add_random_nal();
      int unsigned pick;
      int unsigned len;
      pick = $urandom_range(99);
      len = $urandom_range(1, 16);
      if (pick < 10) begin
         repeat ($urandom_range(1, 3)) begin
            add_item($urandom_range(255), 0, $urandom_range(1), $urandom_range(65535), $urandom);
         end
      end else if (pick < 14) begin
         add_nal($urandom_range(1), 1, $urandom_range(1));
      end else if (pick < 70) begin
         add_nal(len, len, 1);
      end else if (pick < 78) begin
         add_nal(len, $urandom_range(1, len), 1);
      end else if (pick < 86) begin
         add_nal(len + 1, $urandom_range(1, len), 0);
      end else if (pick < 92) begin
         add_nal(len, len, 0);
      end else begin
         add_nal($urandom_range(PAYLOAD_MAX + 1, 65535), $urandom_range(1, 4),
                 $urandom_range(1));
      end
   endtask

   task automatic add_random_run(input int unsigned beats);
      int unsigned goal;
      goal = pending_nal_bytes.size() + beats;
      while (pending_nal_bytes.size() < goal) add_random_nal();
   endtask

   task automatic settle();
      while (pending_nal_bytes.size() != 0 || req_bus.valid || expected_payload.size() != 0)
         @(posedge clock);
      repeat (SETTLE_TAIL) @(posedge clock);
   endtask

   task automatic write_csr(input logic [0:0] idx, input int unsigned value);
      @(negedge clock);
      csr_we    <= 1'b1;
      csr_index <= idx;
      csr_wdata <= value;
      if (idx == CSR_SSRC) begin
         cfg_ssrc = value;
      end else begin
         cfg_pt = 7'(value);
      end
      @(negedge clock);
      csr_we <= 1'b0;
      @(posedge clock);
   endtask

   initial begin : stimulus
      req_bus.valid      = 1'b0;
      req_bus.nal_byte   = 8'd0;
      req_bus.nal_first  = 1'b0;
      req_bus.nal_last   = 1'b0;
      req_bus.nal_length = 16'd0;
      req_bus.frame_time = 32'd0;
      rsp_bus.ready      = 1'b0;
      csr_we             = 1'b0;
      csr_index          = CSR_SSRC;
      csr_wdata          = 32'd0;
      repeat (11) @(negedge clock);
      reset <= 1'b0;
      @(posedge clock);

      add_item(8'h5A, 0, 0, 16'd0, 32'd0);
      add_item(8'hA5, 0, 1, 16'hFFFF, 32'hFFFF_FFFF);
      add_item(8'hFF, 1, 1, 16'd1, 32'hFFFF_FFFF);
      add_item(8'h00, 1, 0, 16'd0, 32'd0);
      add_nal(3, 3, 1);
      add_nal(5, 3, 1);
      add_nal(4, 2, 0);
      add_nal(2, 2, 0);
      add_item(8'h3C, 0, 0, 16'd7, 32'd7);
      add_item(8'hFF, 1, 1, 16'hFFFF, 32'd0);
      add_nal(3000, 3, 1);
      add_nal(2000, 2, 0);
      add_item(8'h00, 1, 1, 16'd1401, 32'h1234_5678);
      add_nal(1, 1, 1);
      add_random_run(50);
      settle();

      write_csr(CSR_SSRC, 32'hFFFF_FFFF);
      write_csr(CSR_PT, 32'd127);
      add_nal(PAYLOAD_MAX, 4, 1);
      add_nal(PAYLOAD_MAX + 1, 3, 1);
      add_nal(PAYLOAD_MAX + 1, 2, 0);
      add_nal(2 * PAYLOAD_MAX + 1, 3, 0);
      add_item(8'h77, 0, 1, 16'd3, 32'd3);
      add_random_run(20);
      settle();

      write_csr(CSR_SSRC, 32'd0);
      write_csr(CSR_PT, 32'd0);
      steady = 1'b1;
      repeat (4) add_item($urandom_range(255), 1, 1, 16'hFFFF, $urandom);
      add_random_run(25);
      settle();
      steady = 1'b0;

      write_csr(CSR_SSRC, $urandom);
      write_csr(CSR_PT, $urandom_range(127));
      add_random_run(25);
      settle();

      if (mismatch_count == 0) begin
         $display("simulation ok");
      end else begin
         $display("simulation failed");
      end
      $finish;
   end

endmodule
